/* hw/rtl/cmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types and constants for the cube map texel lookup block.
// ----------------------------------------------------------------------------
package cmt_pkg;

   // default face edge length in texels
   localparam int FACE_SIZE_DEF = 256;

   localparam int DIR_W   = 16;
   localparam int COLOR_W = 8;
   localparam int FACE_W  = 3;
   localparam int POS_W   = 8;
   localparam int NUM_FACES = 6;

   // request commands
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // face codes
   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

   typedef struct packed {
      logic                     cmd;
      logic signed [DIR_W-1:0]  dir_x;
      logic signed [DIR_W-1:0]  dir_y;
      logic signed [DIR_W-1:0]  dir_z;
      logic [FACE_W-1:0]        wr_face;
      logic [POS_W-1:0]         wr_row;
      logic [POS_W-1:0]         wr_col;
      logic [COLOR_W-1:0]       wr_red;
      logic [COLOR_W-1:0]       wr_green;
      logic [COLOR_W-1:0]       wr_blue;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0]       red;
      logic [COLOR_W-1:0]       green;
      logic [COLOR_W-1:0]       blue;
      logic [FACE_W-1:0]        hit_face;
      logic [POS_W-1:0]         hit_row;
      logic [POS_W-1:0]         hit_col;
   } rsp_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* hw/rtl/cmt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_ram
// Generic single-port RAM, one write and one read per cycle on a shared address, registered read.
// ----------------------------------------------------------------------------
module cmt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/cmt_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmt_div
// Restoring divider, one quotient bit per cycle, MSB first. The caller
// guarantees num < den * 2**QW, so QW steps give the full quotient.
// ----------------------------------------------------------------------------
module cmt_div #(
   parameter int QW = 9,
   parameter int DW = 17,
   parameter int W  = DW + QW
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [W-1:0]         num,
   input  logic [DW-1:0]        den,
   output logic [QW-1:0]        quo,
   output cmt_pkg::div_stat_type stat
);
   import cmt_pkg::*;

   localparam int CW = $clog2(QW + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsh_ff, dsh_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   // one trial subtraction per cycle
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dsh_in  = W'(den) << (QW - 1);
         quo_in  = '0;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo       = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* hw/rtl/cube_map_texel_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_map_texel_lookup
// Six-face RGB texel store with direction lookup: picks the major axis,
// maps the two minor components to column and row, and returns the texel.
//
//   channel   ports                          carries
//   req       req_valid req_ready req_data   texel write or direction lookup
//   rsp       rsp_valid rsp_ready rsp_data   texel and its face, row, column
//
// One request at a time. A write steps through accept and store write.
// A lookup steps through accept, major axis select, divider start, the
// bit-serial dividers for column and row, the store read and output load.
// The result sits in an output register; the next request is taken while
// it waits. Reset clears control only; the store is undefined until written.
// ----------------------------------------------------------------------------
module cube_map_texel_lookup #(
   parameter int FACE_SIZE = cmt_pkg::FACE_SIZE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cmt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cmt_pkg::rsp_type rsp_data
);
   import cmt_pkg::*;

   localparam int DEPTH = NUM_FACES * FACE_SIZE * FACE_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(FACE_SIZE);
   localparam int QW    = $clog2(FACE_SIZE + 1);
   localparam int DW    = DIR_W + 1;
   localparam int NW    = DW + QW;
   localparam int TW    = 3 * COLOR_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PREP  = 6'b000010,
      S_SCALE = 6'b000100,
      S_DIV   = 6'b001000,
      S_ADDR  = 6'b010000,
      S_READ  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff;
   logic [FACE_W-1:0]  face_ff, face_in;
   logic [DIR_W-1:0]   m_ff, m_in;
   logic [DIR_W-1:0]   s_ff, s_in;
   logic [DIR_W-1:0]   t_ff, t_in;
   logic [IW-1:0]      row_ff, row_in;
   logic [IW-1:0]      col_ff, col_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_fire;
   logic               rsp_load;
   logic [DIR_W-1:0]   ax, ay, az;
   logic               wr_ok;
   logic               div_start;
   logic [NW-1:0]      num_s, num_t;
   logic [DW-1:0]      den;
   logic [QW-1:0]      quo_s, quo_t;
   div_stat_type       stat_s, stat_t;
   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_addr;
   logic [FACE_W-1:0]  a_face;
   logic [IW-1:0]      a_row, a_col;
   logic [TW-1:0]      ram_wdata, ram_rdata;

   // scaled offset FACE_SIZE*(c+m); c+m lies in 0..2m
   function automatic logic [NW-1:0] scale_off(logic [DIR_W-1:0] c, logic [DIR_W-1:0] m);
      logic signed [DIR_W+1:0] sum;
      sum = $signed({c[DIR_W-1], c[DIR_W-1], c}) + $signed({2'b00, m});
      return NW'(sum[DIR_W:0]) * NW'(FACE_SIZE);
   endfunction

   // quotient can reach FACE_SIZE at the face edge
   function automatic logic [IW-1:0] clamp_idx(logic [QW-1:0] q);
      if (32'(q) >= FACE_SIZE) begin
         return IW'(FACE_SIZE - 1);
      end
      return IW'(q);
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_READ) && (!rsp_valid_ff || rsp_ready);

   // component magnitudes; -(-32768) wraps to 0x8000, the right magnitude
   assign ax = req_ff.dir_x[DIR_W-1] ? DIR_W'(~req_ff.dir_x + 1'b1) : req_ff.dir_x;
   assign ay = req_ff.dir_y[DIR_W-1] ? DIR_W'(~req_ff.dir_y + 1'b1) : req_ff.dir_y;
   assign az = req_ff.dir_z[DIR_W-1] ? DIR_W'(~req_ff.dir_z + 1'b1) : req_ff.dir_z;

   assign wr_ok = (req_ff.wr_face <= FACE_NEG_Z) && (32'(req_ff.wr_row) < FACE_SIZE)
                  && (32'(req_ff.wr_col) < FACE_SIZE);

   // major axis select; ties go to x, then y
   always_comb begin
      face_in = face_ff;
      m_in    = m_ff;
      s_in    = s_ff;
      t_in    = t_ff;
      if (state_ff == S_PREP) begin
         if (ax >= ay && ax >= az) begin
            face_in = req_ff.dir_x[DIR_W-1] ? FACE_NEG_X : FACE_POS_X;
            m_in    = ax;
            s_in    = req_ff.dir_y;
            t_in    = req_ff.dir_z;
         end else if (ay >= az) begin
            face_in = req_ff.dir_y[DIR_W-1] ? FACE_NEG_Y : FACE_POS_Y;
            m_in    = ay;
            s_in    = req_ff.dir_x;
            t_in    = req_ff.dir_z;
         end else begin
            face_in = req_ff.dir_z[DIR_W-1] ? FACE_NEG_Z : FACE_POS_Z;
            m_in    = az;
            s_in    = req_ff.dir_x;
            t_in    = req_ff.dir_y;
         end
      end
   end

   // divider operands
   assign div_start = (state_ff == S_SCALE);
   assign num_s     = scale_off(s_ff, m_ff);
   assign num_t     = scale_off(t_ff, m_ff);
   assign den       = {m_ff, 1'b0};

   cmt_div #(.QW(QW), .DW(DW), .W(NW)) u_div_col (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_s),
      .den   (den),
      .quo   (quo_s),
      .stat  (stat_s)
   );

   cmt_div #(.QW(QW), .DW(DW), .W(NW)) u_div_row (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_t),
      .den   (den),
      .quo   (quo_t),
      .stat  (stat_t)
   );

   // texel index; a zero vector reads texel (0,0)
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (state_ff == S_DIV && stat_s.done) begin
         if (m_ff == '0) begin
            row_in = '0;
            col_in = '0;
         end else begin
            row_in = clamp_idx(quo_t);
            col_in = clamp_idx(quo_s);
         end
      end
   end

   // store port: write from the request, read from the lookup
   always_comb begin
      if (state_ff == S_PREP) begin
         a_face = req_ff.wr_face;
         a_row  = IW'(req_ff.wr_row);
         a_col  = IW'(req_ff.wr_col);
      end else begin
         a_face = face_ff;
         a_row  = row_ff;
         a_col  = col_ff;
      end
   end

   assign ram_addr  = AW'(a_face) * AW'(FACE_SIZE * FACE_SIZE)
                      + AW'(a_row) * AW'(FACE_SIZE) + AW'(a_col);
   assign ram_we    = (state_ff == S_PREP) && (req_ff.cmd == CMD_WRITE) && wr_ok;
   assign ram_re    = (state_ff == S_ADDR);
   assign ram_wdata = {req_ff.wr_red, req_ff.wr_green, req_ff.wr_blue};

   cmt_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = (req_ff.cmd == CMD_WRITE) ? S_IDLE : S_SCALE;
         end
         S_SCALE: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (stat_s.done) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            state_in = S_READ;
         end
         S_READ: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      face_ff <= face_in;
      m_ff    <= m_in;
      s_ff    <= s_in;
      t_ff    <= t_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      if (rsp_load) begin
         rsp_ff.red      <= ram_rdata[3*COLOR_W-1:2*COLOR_W];
         rsp_ff.green    <= ram_rdata[2*COLOR_W-1:COLOR_W];
         rsp_ff.blue     <= ram_rdata[COLOR_W-1:0];
         rsp_ff.hit_face <= face_ff;
         rsp_ff.hit_row  <= POS_W'(row_ff);
         rsp_ff.hit_col  <= POS_W'(col_ff);
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_READ))
      else $error("response raised outside the read step");

   a_write_only_prep: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_PREP) && (req_ff.cmd == CMD_WRITE))
      else $error("store written outside a write request");

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (stat_s.busy || stat_s.done) && (stat_s == stat_t))
      else $error("dividers idle or out of step during division");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADDR) |-> (32'(row_ff) < FACE_SIZE) && (32'(col_ff) < FACE_SIZE)
                               && (face_ff <= FACE_NEG_Z))
      else $error("lookup address out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_ff))
      else $error("pending response overwritten");

endmodule

/* verif/cube_map_texel_lookup_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_map_texel_lookup_tb
// Self-checking bench for the cube map texel lookup block. A queue of texel
// writes and direction lookups is built up front. The queue starts with
// directed corner cases: zero vector, every face, axis ties, clamped edges
// and dropped writes. Random traffic follows. Every lookup targets a texel
// that was written earlier. An in-bench predictor keeps its own copy of the
// texel store. It computes the face, row, column and color for each accepted
// lookup. Responses are checked field by field in order. Both handshakes are
// throttled at random.
// ----------------------------------------------------------------------------
module cube_map_texel_lookup_tb;
   import cmt_pkg::*;

   localparam int FACE_SIZE      = FACE_SIZE_DEF;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int POOL_DEPTH     = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 32;

   // face codes past the last face; writes to these are dropped
   localparam logic [FACE_W-1:0] FACE_BAD_LO = 3'd6;
   localparam logic [FACE_W-1:0] FACE_BAD_HI = 3'd7;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PATTERN
   } ready_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // requests waiting to be driven, lookups waiting for their response
   req_type pending_reqs[$];
   rsp_type expected_texels[$];

   // predictor's texel store, and the generator's record of written texels
   logic [23:0] texel_mem[int];
   bit          texel_written[int];

   // frequently revisited directions, so that lookups see overwritten texels
   logic signed [DIR_W-1:0] pool_x[POOL_DEPTH];
   logic signed [DIR_W-1:0] pool_y[POOL_DEPTH];
   logic signed [DIR_W-1:0] pool_z[POOL_DEPTH];

   logic           req_taken   = 1'b0;
   int             gap_left    = 0;
   int             burst_left  = 1;
   int             mode_left   = 0;
   int             idle_cycles = 0;
   ready_mode_type ready_mode  = READY_ALWAYS;
   logic [7:0]     stall_mask  = 8'hA5;
   logic           drv_valid;
   req_type        drv_data;
   logic           rdy_next;
   rsp_type        want_rsp;

   int stim_count = 0;
   int n_writes   = 0;
   int n_dropped  = 0;
   int n_lookups  = 0;
   int n_checked  = 0;
   int n_errors   = 0;

   cube_map_texel_lookup #(
      .FACE_SIZE (FACE_SIZE)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // floor(FACE_SIZE*(c+m)/(2m)), clamped to the last texel
   function automatic int axis_to_texel(int c, int m);
      longint scaled;
      longint q;
      scaled = longint'(FACE_SIZE) * longint'(c + m);
      q = scaled / (2 * longint'(m));
      if (q > FACE_SIZE - 1) q = FACE_SIZE - 1;
      return int'(q);
   endfunction

   // major axis wins, ties go to x then y; zero vector lands on +x (0,0)
   function automatic void map_direction(input logic signed [DIR_W-1:0] dx, dy, dz,
                                         output logic [FACE_W-1:0] face,
                                         output int row, col);
      int x, y, z, ax, ay, az, m, s, t;
      x = dx;
      y = dy;
      z = dz;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      if (ax >= ay && ax >= az) begin
         face = (x < 0) ? FACE_NEG_X : FACE_POS_X;
         m = ax; s = y; t = z;
      end else if (ay >= az) begin
         face = (y < 0) ? FACE_NEG_Y : FACE_POS_Y;
         m = ay; s = x; t = z;
      end else begin
         face = (z < 0) ? FACE_NEG_Z : FACE_POS_Z;
         m = az; s = x; t = y;
      end
      if (m > 0) begin
         col = axis_to_texel(s, m);
         row = axis_to_texel(t, m);
      end else begin
         col = 0;
         row = 0;
      end
   endfunction

   function automatic int texel_addr(logic [FACE_W-1:0] face, int row, int col);
      return (int'(face) * FACE_SIZE + row) * FACE_SIZE + col;
   endfunction

   function automatic rsp_type lookup_texel(req_type r);
      rsp_type            o;
      logic [FACE_W-1:0]  face;
      int                 row, col, addr;
      logic [23:0]        texel;
      map_direction(r.dir_x, r.dir_y, r.dir_z, face, row, col);
      addr  = texel_addr(face, row, col);
      texel = texel_mem.exists(addr) ? texel_mem[addr] : 24'h0;
      o.red      = texel[23:16];
      o.green    = texel[15:8];
      o.blue     = texel[7:0];
      o.hit_face = face;
      o.hit_row  = row[POS_W-1:0];
      o.hit_col  = col[POS_W-1:0];
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Request generation
   // ------------------------------------------------------------------

   task automatic push_write(logic [FACE_W-1:0] face, logic [POS_W-1:0] row,
                             logic [POS_W-1:0] col, logic [23:0] rgb);
      req_type r;
      r.cmd     = CMD_WRITE;
      r.dir_x   = 16'($urandom);
      r.dir_y   = 16'($urandom);
      r.dir_z   = 16'($urandom);
      r.wr_face = face;
      r.wr_row  = row;
      r.wr_col  = col;
      {r.wr_red, r.wr_green, r.wr_blue} = rgb;
      pending_reqs.push_back(r);
      if (face < NUM_FACES) begin
         texel_written[texel_addr(face, row, col)] = 1'b1;
         stim_count++;
      end
   endtask

   task automatic push_lookup(logic signed [DIR_W-1:0] dx, dy, dz);
      req_type           r;
      logic [FACE_W-1:0] face;
      int                row, col;
      map_direction(dx, dy, dz, face, row, col);
      // store is undefined until written: paint the target first if needed
      if (!texel_written.exists(texel_addr(face, row, col)))
         push_write(face, row[POS_W-1:0], col[POS_W-1:0], 24'($urandom));
      r.cmd      = CMD_LOOKUP;
      r.dir_x    = dx;
      r.dir_y    = dy;
      r.dir_z    = dz;
      r.wr_face  = 3'($urandom);
      r.wr_row   = 8'($urandom);
      r.wr_col   = 8'($urandom);
      r.wr_red   = 8'($urandom);
      r.wr_green = 8'($urandom);
      r.wr_blue  = 8'($urandom);
      pending_reqs.push_back(r);
      stim_count++;
   endtask

   task automatic random_direction(output logic signed [DIR_W-1:0] dx, dy, dz);
      int m, a, b, third;
      int extremes[5] = '{-32768, 32767, 0, -1, 1};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            dx = 16'($urandom);
            dy = 16'($urandom);
            dz = 16'($urandom);
         end
         // tiny vectors: coarse texel steps and many ties
         4: begin
            dx = 16'(int'($urandom_range(0, 8)) - 4);
            dy = 16'(int'($urandom_range(0, 8)) - 4);
            dz = 16'(int'($urandom_range(0, 8)) - 4);
         end
         // two or three components of equal magnitude
         5: begin
            m     = $urandom_range(1, 32767);
            a     = $urandom_range(0, 1) ? m : -m;
            b     = $urandom_range(0, 1) ? m : -m;
            third = int'($urandom_range(0, 2 * m)) - m;
            case ($urandom_range(0, 3))
               0: begin dx = 16'(a); dy = 16'(b); dz = 16'(third); end
               1: begin dx = 16'(third); dy = 16'(a); dz = 16'(b); end
               2: begin dx = 16'(a); dy = 16'(third); dz = 16'(b); end
               default: begin
                  dx = 16'(a);
                  dy = 16'(b);
                  dz = 16'($urandom_range(0, 1) ? m : -m);
               end
            endcase
         end
         6: begin
            dx = 16'(extremes[$urandom_range(0, 4)]);
            dy = 16'(extremes[$urandom_range(0, 4)]);
            dz = 16'(extremes[$urandom_range(0, 4)]);
         end
         // one dominant axis, minors spread over the whole face
         default: begin
            m     = $urandom_range(1, 32767);
            a     = int'($urandom_range(0, 2 * m)) - m;
            b     = int'($urandom_range(0, 2 * m)) - m;
            third = $urandom_range(0, 1) ? m : -m;
            case ($urandom_range(0, 2))
               0: begin dx = 16'(third); dy = 16'(a); dz = 16'(b); end
               1: begin dx = 16'(a); dy = 16'(third); dz = 16'(b); end
               default: begin dx = 16'(a); dy = 16'(b); dz = 16'(third); end
            endcase
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Request driver: bursts with random gaps
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drv_valid = req_valid;
         drv_data  = req_data;
         if (req_valid && req_taken) drv_valid = 1'b0;
         if (!drv_valid) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
               drv_data  = pending_reqs.pop_front();
               drv_valid = 1'b1;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
               end
            end
         end
         req_valid <= drv_valid;
         req_data  <= drv_data;
      end
   end

   // ------------------------------------------------------------------
   // Response ready: stall mode drawn at random, redrawn when its run ends
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(16, 96);
         stall_mask = 8'($urandom_range(1, 255));
      end else begin
         mode_left = mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rdy_next = 1'b1;
         READY_COIN:   rdy_next = 1'($urandom_range(0, 1));
         READY_SPARSE: rdy_next = ($urandom_range(0, 3) == 0);
         default: begin
            rdy_next   = stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[7:1]};
         end
      endcase
      rsp_ready <= rdy_next;
   end

   // ------------------------------------------------------------------
   // Monitor: check responses, then predict accepted requests
   // ------------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         // response side first, so a spurious response never meets a fresh lookup
         if (rsp_valid && rsp_ready) begin
            if (expected_texels.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, got %h",
                        $time, rsp_data);
               n_errors++;
            end else begin
               want_rsp = expected_texels.pop_front();
               check_field("red",      want_rsp.red,      rsp_data.red);
               check_field("green",    want_rsp.green,    rsp_data.green);
               check_field("blue",     want_rsp.blue,     rsp_data.blue);
               check_field("hit_face", want_rsp.hit_face, rsp_data.hit_face);
               check_field("hit_row",  want_rsp.hit_row,  rsp_data.hit_row);
               check_field("hit_col",  want_rsp.hit_col,  rsp_data.hit_col);
               n_checked++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.cmd == CMD_WRITE) begin
               if (req_data.wr_face < NUM_FACES && req_data.wr_row < FACE_SIZE &&
                   req_data.wr_col < FACE_SIZE) begin
                  texel_mem[texel_addr(req_data.wr_face, req_data.wr_row, req_data.wr_col)] =
                     {req_data.wr_red, req_data.wr_green, req_data.wr_blue};
                  n_writes++;
               end else begin
                  n_dropped++;
               end
            end else begin
               expected_texels.push_back(lookup_texel(req_data));
               n_lookups++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: no handshake on either channel for too long
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d lookups outstanding",
                  $time, idle_cycles, expected_texels.size());
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic signed [DIR_W-1:0] dx, dy, dz;
      logic [FACE_W-1:0]       face;
      int                      row, col, sel, idx, directed_count;

      // directed: corners of the store, dropped writes, every face, ties, edges
      push_write(FACE_POS_X, 8'd0, 8'd0, 24'hFF00FF);
      push_write(FACE_NEG_Z, 8'd255, 8'd255, 24'h00FF00);
      push_write(FACE_BAD_LO, 8'd0, 8'd0, 24'hFFFFFF);
      push_write(FACE_BAD_HI, 8'd255, 8'd255, 24'h000000);
      push_lookup(16'sd0, 16'sd0, 16'sd0);                 // zero vector
      push_lookup(16'sh7FFF, 16'sd0, 16'sd0);
      push_lookup(16'sh8000, 16'sd0, 16'sd0);
      push_lookup(16'sd0, 16'sd100, -16'sd3);
      push_lookup(16'sd5, -16'sd200, 16'sd7);
      push_lookup(16'sd1, 16'sd2, 16'sd300);
      push_lookup(16'sd0, 16'sd0, -16'sd1);
      push_lookup(16'sh8000, 16'sh8000, 16'sh8000);         // all tie, low edge
      push_lookup(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);         // all tie, clamped
      push_lookup(16'sd7, -16'sd9, 16'sd9);                 // y/z tie, row clamp
      push_lookup(-16'sd5, 16'sd5, 16'sd1);                 // x/y tie
      push_lookup(16'sh7FFF, 16'sh7FFF, 16'sh8000);         // -z, far corner
      push_lookup(16'sd0, 16'sh8000, 16'sh7FFF);
      push_write(FACE_POS_X, 8'd0, 8'd0, 24'h000000);
      push_lookup(16'sd0, 16'sd0, 16'sd0);                 // sees the overwrite
      directed_count = stim_count;

      for (int i = 0; i < POOL_DEPTH; i++)
         random_direction(pool_x[i], pool_y[i], pool_z[i]);

      // random: mostly lookups, with repaints of revisited texels and some noise
      while (stim_count - directed_count < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            idx = $urandom_range(0, POOL_DEPTH - 1);
            push_lookup(pool_x[idx], pool_y[idx], pool_z[idx]);
         end else if (sel < 65) begin
            random_direction(dx, dy, dz);
            push_lookup(dx, dy, dz);
         end else if (sel < 80) begin
            idx = $urandom_range(0, POOL_DEPTH - 1);
            map_direction(pool_x[idx], pool_y[idx], pool_z[idx], face, row, col);
            push_write(face, row[POS_W-1:0], col[POS_W-1:0], 24'($urandom));
         end else if (sel < 95) begin
            push_write(3'($urandom_range(0, NUM_FACES - 1)), 8'($urandom), 8'($urandom),
                       24'($urandom));
         end else begin
            push_write($urandom_range(0, 1) ? FACE_BAD_HI : FACE_BAD_LO, 8'($urandom),
                       8'($urandom), 24'($urandom));
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_texels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d stored texel writes, %0d dropped writes and %0d lookups",
               n_writes, n_dropped, n_lookups);
      $display("%0d responses compared across all six faces, %0d mismatches",
               n_checked, n_errors);
      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/cmt_pkg.sv
hw/rtl/cmt_ram.sv
hw/rtl/cmt_div.sv
hw/rtl/cube_map_texel_lookup.sv
verif/cube_map_texel_lookup_tb.sv
